/* rtl/vang_pkg.sv */
// shared constants and tables for the vertex angle pipeline
`default_nettype none
package vang_pkg;

    localparam int COORD_BITS_DEF = 16;

    // datapath widths
    localparam int RW           = 64;
    localparam int EW           = 6;
    localparam int ROOT_W       = 31;
    localparam int QW           = 32;
    localparam int CW           = 31;
    localparam int XW           = 34;
    localparam int ZW           = 32;
    localparam int ANG_W        = 15;

    // step counts and top bit positions
    localparam int SQRT_STEPS   = 31;
    localparam int SQRT_TOP_BIT = 60;
    localparam int NORM_TOP     = 60;
    localparam int DIV_STEPS    = 32;
    localparam int CORDIC_STEPS = 28;

    localparam logic [CW-1:0]   ONE_Q30        = CW'(1) << 30;
    localparam logic [RW-1:0]   ONE_Q60        = RW'(1) << 60;
    localparam logic signed [ZW:0] HALF_TURN_Q16 = (ZW+1)'(64'd1179648000);
    localparam logic [16:0]     MAX_CENTIDEG   = 17'd18000;
    localparam logic [ZW:0]     ROUND_HALF     = (ZW+1)'(32768);

    // atan(2^-i) in 2^-16 centidegree
    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic signed [ZW-1:0] t;
        begin
            unique case (i)
                0:  t = 32'sd294912000;
                1:  t = 32'sd174096719;
                2:  t = 32'sd91987925;
                3:  t = 32'sd46694507;
                4:  t = 32'sd23437865;
                5:  t = 32'sd11730358;
                6:  t = 32'sd5866610;
                7:  t = 32'sd2933484;
                8:  t = 32'sd1466764;
                9:  t = 32'sd733385;
                10: t = 32'sd366693;
                11: t = 32'sd183346;
                12: t = 32'sd91673;
                13: t = 32'sd45837;
                14: t = 32'sd22918;
                15: t = 32'sd11459;
                16: t = 32'sd5730;
                17: t = 32'sd2865;
                18: t = 32'sd1432;
                19: t = 32'sd716;
                20: t = 32'sd358;
                21: t = 32'sd179;
                22: t = 32'sd90;
                23: t = 32'sd45;
                24: t = 32'sd22;
                25: t = 32'sd11;
                26: t = 32'sd6;
                27: t = 32'sd3;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/vang_sqrt_cell.sv */
// one digit step of the integer square root chain
`default_nettype none
module vang_sqrt_cell
    import vang_pkg::*;
#(
    parameter int BIT_POS = 60,
    parameter int PW      = 1
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_vld,
    input  wire logic [RW-1:0] in_rem,
    input  wire logic [RW-1:0] in_root,
    input  wire logic [PW-1:0] in_pay,
    output logic               out_vld,
    output logic [RW-1:0]      out_rem,
    output logic [RW-1:0]      out_root,
    output logic [PW-1:0]      out_pay
);

    localparam logic [RW-1:0] BIT_VAL = RW'(1) << BIT_POS;

    logic          vld_reg;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] root_reg, root_next;
    logic [PW-1:0] pay_reg;
    logic [RW-1:0] trial;

    always_comb
    begin
        trial = in_root + BIT_VAL;
        if (in_rem >= trial)
        begin
            rem_next  = in_rem - trial;
            root_next = (in_root >> 1) + BIT_VAL;
        end
        else
        begin
            rem_next  = in_rem;
            root_next = in_root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        pay_reg  <= in_pay;
    end

    assign out_vld  = vld_reg;
    assign out_rem  = rem_reg;
    assign out_root = root_reg;
    assign out_pay  = pay_reg;

endmodule
`default_nettype wire

/* rtl/vang_div_cell.sv */
// one quotient bit of the restoring divider chain
`default_nettype none
module vang_div_cell
    import vang_pkg::*;
#(
    parameter int SHIFT = 0,
    parameter int PW    = 1
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_vld,
    input  wire logic [RW-1:0] in_rem,
    input  wire logic [QW-1:0] in_quo,
    input  wire logic [QW-1:0] in_den,
    input  wire logic [PW-1:0] in_pay,
    output logic               out_vld,
    output logic [RW-1:0]      out_rem,
    output logic [QW-1:0]      out_quo,
    output logic [QW-1:0]      out_den,
    output logic [PW-1:0]      out_pay
);

    logic          vld_reg;
    logic [RW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [QW-1:0] den_reg;
    logic [PW-1:0] pay_reg;
    logic [RW-1:0] trial;
    logic          take;

    always_comb
    begin
        trial    = RW'(in_den) << SHIFT;
        take     = (in_rem >= trial);
        rem_next = take ? (in_rem - trial) : in_rem;
        quo_next = {in_quo[QW-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= in_den;
        pay_reg <= in_pay;
    end

    assign out_vld = vld_reg;
    assign out_rem = rem_reg;
    assign out_quo = quo_reg;
    assign out_den = den_reg;
    assign out_pay = pay_reg;

endmodule
`default_nettype wire

/* rtl/vang_cordic_cell.sv */
// one vectoring rotation of the cordic chain
`default_nettype none
module vang_cordic_cell
    import vang_pkg::*;
#(
    parameter int STEP = 0,
    parameter int PW   = 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_vld,
    input  wire logic signed [XW-1:0] in_x,
    input  wire logic signed [XW-1:0] in_y,
    input  wire logic signed [ZW-1:0] in_z,
    input  wire logic [PW-1:0]        in_pay,
    output logic                      out_vld,
    output logic signed [XW-1:0]      out_x,
    output logic signed [XW-1:0]      out_y,
    output logic signed [ZW-1:0]      out_z,
    output logic [PW-1:0]             out_pay
);

    localparam logic signed [ZW-1:0] ANGLE = atan_q16(STEP);

    logic                 vld_reg;
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [PW-1:0]        pay_reg;
    logic signed [XW-1:0] xs;
    logic [XW-1:0]        ymag;
    logic signed [XW-1:0] ys;

    always_comb
    begin
        xs   = in_x >>> STEP;
        ymag = in_y[XW-1] ? XW'(-in_y) : XW'(in_y);
        ys   = $signed(ymag >> STEP);
        x_next = in_x;
        y_next = in_y;
        z_next = in_z;
        if (in_y[XW-1])
        begin
            x_next = in_x + ys;
            y_next = in_y + xs;
            z_next = in_z - ANGLE;
        end
        else if (in_y != '0)
        begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        pay_reg <= in_pay;
    end

    assign out_vld = vld_reg;
    assign out_x   = x_reg;
    assign out_y   = y_reg;
    assign out_z   = z_reg;
    assign out_pay = pay_reg;

endmodule
`default_nettype wire

/* rtl/three_point_vertex_angle_top.sv */
// vertex angle of three 3d points, fully pipelined chain of cells
// done follows stages 1-5, length sqrt, stage 6, divider, stages 8-9, sine sqrt, cordic, output
// throughput: one request per cycle, busy is always low
// depth is set by the 31-cell length and sine square root chains, the 32-cell divider
// chain and the 28-cell cordic chain; results cannot be stalled
// reset: rst_n clears all valid bits, payload registers are not reset
`default_nettype none
module three_point_vertex_angle_top
    import vang_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [COORD_BITS-1:0] a_x,
    input  wire logic signed [COORD_BITS-1:0] a_y,
    input  wire logic signed [COORD_BITS-1:0] a_z,
    input  wire logic signed [COORD_BITS-1:0] b_x,
    input  wire logic signed [COORD_BITS-1:0] b_y,
    input  wire logic signed [COORD_BITS-1:0] b_z,
    input  wire logic signed [COORD_BITS-1:0] c_x,
    input  wire logic signed [COORD_BITS-1:0] c_y,
    input  wire logic signed [COORD_BITS-1:0] c_z,
    output logic                              done,
    output logic [ANG_W-1:0]                  angle_centideg,
    output logic                              degenerate
);

    // difference, product and sum widths follow the coordinate width
    localparam int DW  = COORD_BITS + 1;
    localparam int PRW = 2 * DW;
    localparam int SW  = PRW + 2;

    // even left shift that brings a nonzero sum into [2^60, 2^62)
    function automatic logic [EW-1:0] norm_shift(input logic [SW-1:0] s);
        int p;
        begin
            p = 0;
            for (int k = 0; k < SW; k++)
            begin
                if (s[k])
                    p = k;
            end
            return EW'(NORM_TOP - (p & ~1));
        end
    endfunction

    assign busy = 1'b0;

    // stage 1: edge vectors u = a - b, v = c - b
    logic                 v1_reg;
    logic signed [DW-1:0] du_reg [3];
    logic signed [DW-1:0] dv_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        du_reg[0] <= {a_x[COORD_BITS-1], a_x} - {b_x[COORD_BITS-1], b_x};
        du_reg[1] <= {a_y[COORD_BITS-1], a_y} - {b_y[COORD_BITS-1], b_y};
        du_reg[2] <= {a_z[COORD_BITS-1], a_z} - {b_z[COORD_BITS-1], b_z};
        dv_reg[0] <= {c_x[COORD_BITS-1], c_x} - {b_x[COORD_BITS-1], b_x};
        dv_reg[1] <= {c_y[COORD_BITS-1], c_y} - {b_y[COORD_BITS-1], b_y};
        dv_reg[2] <= {c_z[COORD_BITS-1], c_z} - {b_z[COORD_BITS-1], b_z};
    end

    // stage 2: per-axis squares and dot terms
    logic                  v2_reg;
    logic [PRW-1:0]        squ_reg [3];
    logic [PRW-1:0]        sqv_reg [3];
    logic signed [PRW-1:0] dp_reg  [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            squ_reg[i] <= du_reg[i] * du_reg[i];
            sqv_reg[i] <= dv_reg[i] * dv_reg[i];
            dp_reg[i]  <= du_reg[i] * dv_reg[i];
        end
    end

    // stage 3: squared lengths and dot product
    logic                 v3_reg;
    logic [SW-1:0]        su_reg;
    logic [SW-1:0]        sv_reg;
    logic signed [SW-1:0] d3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        su_reg <= SW'(squ_reg[0]) + SW'(squ_reg[1]) + SW'(squ_reg[2]);
        sv_reg <= SW'(sqv_reg[0]) + SW'(sqv_reg[1]) + SW'(sqv_reg[2]);
        d3_reg <= SW'(dp_reg[0]) + SW'(dp_reg[1]) + SW'(dp_reg[2]);
    end

    // stage 4: normalizing shifts and degenerate check
    logic                 v4_reg;
    logic [EW-1:0]        eu_reg;
    logic [EW-1:0]        ev_reg;
    logic [SW-1:0]        su4_reg;
    logic [SW-1:0]        sv4_reg;
    logic signed [SW-1:0] d4_reg;
    logic                 dg4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        eu_reg  <= norm_shift(su_reg);
        ev_reg  <= norm_shift(sv_reg);
        su4_reg <= su_reg;
        sv4_reg <= sv_reg;
        d4_reg  <= d3_reg;
        dg4_reg <= (su_reg == '0) || (sv_reg == '0);
    end

    // stage 5: scaled lengths squared and scaled dot magnitude
    logic          v5_reg;
    logic [RW-1:0] nu_reg;
    logic [RW-1:0] nv_reg;
    logic [RW-1:0] num5_reg;
    logic          neg5_reg;
    logic          dg5_reg;
    logic [SW-1:0] dmag;
    logic [EW:0]   esum;

    always_comb
    begin
        dmag = d4_reg[SW-1] ? SW'(-d4_reg) : SW'(d4_reg);
        esum = {1'b0, eu_reg} + {1'b0, ev_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        nu_reg   <= RW'(su4_reg) << eu_reg;
        nv_reg   <= RW'(sv4_reg) << ev_reg;
        num5_reg <= RW'(dmag) << esum[EW:1];
        neg5_reg <= d4_reg[SW-1];
        dg5_reg  <= dg4_reg;
    end

    // square root chains for both side lengths
    localparam int PUW = RW + 1;
    logic           sa_vld  [0:SQRT_STEPS];
    logic [RW-1:0]  sa_rem  [0:SQRT_STEPS];
    logic [RW-1:0]  sa_root [0:SQRT_STEPS];
    logic [PUW-1:0] sa_pay  [0:SQRT_STEPS];
    logic           sb_vld  [0:SQRT_STEPS];
    logic [RW-1:0]  sb_rem  [0:SQRT_STEPS];
    logic [RW-1:0]  sb_root [0:SQRT_STEPS];
    logic [0:0]     sb_pay  [0:SQRT_STEPS];

    assign sa_vld[0]  = v5_reg;
    assign sa_rem[0]  = nu_reg;
    assign sa_root[0] = '0;
    assign sa_pay[0]  = {num5_reg, neg5_reg};
    assign sb_vld[0]  = v5_reg;
    assign sb_rem[0]  = nv_reg;
    assign sb_root[0] = '0;
    assign sb_pay[0]  = dg5_reg;

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_len_sqrt
        vang_sqrt_cell #(
            .BIT_POS (SQRT_TOP_BIT - 2 * j),
            .PW      (PUW)
        ) u_cell_u (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (sa_vld[j]),
            .in_rem   (sa_rem[j]),
            .in_root  (sa_root[j]),
            .in_pay   (sa_pay[j]),
            .out_vld  (sa_vld[j+1]),
            .out_rem  (sa_rem[j+1]),
            .out_root (sa_root[j+1]),
            .out_pay  (sa_pay[j+1])
        );
        vang_sqrt_cell #(
            .BIT_POS (SQRT_TOP_BIT - 2 * j),
            .PW      (1)
        ) u_cell_v (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (sb_vld[j]),
            .in_rem   (sb_rem[j]),
            .in_root  (sb_root[j]),
            .in_pay   (sb_pay[j]),
            .out_vld  (sb_vld[j+1]),
            .out_rem  (sb_rem[j+1]),
            .out_root (sb_root[j+1]),
            .out_pay  (sb_pay[j+1])
        );
    end

    // stage 6: product of the scaled lengths
    logic                     v6_reg;
    logic [2*ROOT_W-1:0]      lp_reg;
    logic [RW-1:0]            num6_reg;
    logic                     neg6_reg;
    logic                     dg6_reg;
    logic [ROOT_W-1:0]        lu;
    logic [ROOT_W-1:0]        lv;

    assign lu = sa_root[SQRT_STEPS][ROOT_W-1:0];
    assign lv = sb_root[SQRT_STEPS][ROOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else
            v6_reg <= sa_vld[SQRT_STEPS] & sb_vld[SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        lp_reg   <= lu * lv;
        num6_reg <= sa_pay[SQRT_STEPS][PUW-1:1];
        neg6_reg <= sa_pay[SQRT_STEPS][0];
        dg6_reg  <= sb_pay[SQRT_STEPS][0];
    end

    // cosine magnitude: restoring divider chain, one quotient bit a cell
    logic          dv_vld [0:DIV_STEPS];
    logic [RW-1:0] dv_rem [0:DIV_STEPS];
    logic [QW-1:0] dv_quo [0:DIV_STEPS];
    logic [QW-1:0] dv_den [0:DIV_STEPS];
    logic [1:0]    dv_pay [0:DIV_STEPS];

    assign dv_vld[0] = v6_reg;
    assign dv_rem[0] = num6_reg;
    assign dv_quo[0] = '0;
    assign dv_den[0] = lp_reg[2*ROOT_W-1:30];
    assign dv_pay[0] = {neg6_reg, dg6_reg};

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        vang_div_cell #(
            .SHIFT (DIV_STEPS - 1 - j),
            .PW    (2)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_vld  (dv_vld[j]),
            .in_rem  (dv_rem[j]),
            .in_quo  (dv_quo[j]),
            .in_den  (dv_den[j]),
            .in_pay  (dv_pay[j]),
            .out_vld (dv_vld[j+1]),
            .out_rem (dv_rem[j+1]),
            .out_quo (dv_quo[j+1]),
            .out_den (dv_den[j+1]),
            .out_pay (dv_pay[j+1])
        );
    end

    // stage 8: clamp cosine to one, square it
    logic                v8_reg;
    logic [CW-1:0]       c8_reg;
    logic [2*CW-1:0]     csq_reg;
    logic [1:0]          p8_reg;
    logic [CW-1:0]       c_clamp;

    assign c_clamp = (dv_quo[DIV_STEPS] > QW'(ONE_Q30)) ? ONE_Q30
                                                        : dv_quo[DIV_STEPS][CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else
            v8_reg <= dv_vld[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        c8_reg  <= c_clamp;
        csq_reg <= c_clamp * c_clamp;
        p8_reg  <= dv_pay[DIV_STEPS];
    end

    // stage 9: one minus cosine squared
    logic          v9_reg;
    logic [RW-1:0] rad_reg;
    logic [CW-1:0] c9_reg;
    logic [1:0]    p9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v9_reg <= 1'b0;
        else
            v9_reg <= v8_reg;
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= ONE_Q60 - RW'(csq_reg);
        c9_reg  <= c8_reg;
        p9_reg  <= p8_reg;
    end

    // sine from the square root chain
    localparam int PSW = CW + 2;
    logic           ss_vld  [0:SQRT_STEPS];
    logic [RW-1:0]  ss_rem  [0:SQRT_STEPS];
    logic [RW-1:0]  ss_root [0:SQRT_STEPS];
    logic [PSW-1:0] ss_pay  [0:SQRT_STEPS];

    assign ss_vld[0]  = v9_reg;
    assign ss_rem[0]  = rad_reg;
    assign ss_root[0] = '0;
    assign ss_pay[0]  = {c9_reg, p9_reg};

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sin_sqrt
        vang_sqrt_cell #(
            .BIT_POS (SQRT_TOP_BIT - 2 * j),
            .PW      (PSW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (ss_vld[j]),
            .in_rem   (ss_rem[j]),
            .in_root  (ss_root[j]),
            .in_pay   (ss_pay[j]),
            .out_vld  (ss_vld[j+1]),
            .out_rem  (ss_rem[j+1]),
            .out_root (ss_root[j+1]),
            .out_pay  (ss_pay[j+1])
        );
    end

    // angle from atan2(sine, cosine) by vectoring cordic
    logic                 cd_vld [0:CORDIC_STEPS];
    logic signed [XW-1:0] cd_x   [0:CORDIC_STEPS];
    logic signed [XW-1:0] cd_y   [0:CORDIC_STEPS];
    logic signed [ZW-1:0] cd_z   [0:CORDIC_STEPS];
    logic [1:0]           cd_pay [0:CORDIC_STEPS];

    assign cd_vld[0] = ss_vld[SQRT_STEPS];
    assign cd_x[0]   = $signed(XW'(ss_pay[SQRT_STEPS][PSW-1:2]));
    assign cd_y[0]   = $signed(XW'(ss_root[SQRT_STEPS][ROOT_W-1:0]));
    assign cd_z[0]   = '0;
    assign cd_pay[0] = ss_pay[SQRT_STEPS][1:0];

    for (genvar j = 0; j < CORDIC_STEPS; j++)
    begin : g_cordic
        vang_cordic_cell #(
            .STEP (j),
            .PW   (2)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_vld  (cd_vld[j]),
            .in_x    (cd_x[j]),
            .in_y    (cd_y[j]),
            .in_z    (cd_z[j]),
            .in_pay  (cd_pay[j]),
            .out_vld (cd_vld[j+1]),
            .out_x   (cd_x[j+1]),
            .out_y   (cd_y[j+1]),
            .out_z   (cd_z[j+1]),
            .out_pay (cd_pay[j+1])
        );
    end

    // output stage: mirror for obtuse angles, clamp and round to centidegrees, zero if degenerate
    logic                done_reg;
    logic [ANG_W-1:0]    angle_reg;
    logic                degen_reg;
    logic signed [ZW:0]  ang;
    logic signed [ZW:0]  ang_c;
    logic [ZW:0]         ang_r;
    logic [16:0]         cdeg;
    logic [ANG_W-1:0]    angle_next;
    logic                neg_f;
    logic                dg_f;

    always_comb
    begin
        neg_f = cd_pay[CORDIC_STEPS][1];
        dg_f  = cd_pay[CORDIC_STEPS][0];
        ang   = neg_f ? (HALF_TURN_Q16 - (ZW+1)'(cd_z[CORDIC_STEPS]))
                      : (ZW+1)'(cd_z[CORDIC_STEPS]);
        if (ang < 0)
            ang_c = '0;
        else if (ang > HALF_TURN_Q16)
            ang_c = HALF_TURN_Q16;
        else
            ang_c = ang;
        ang_r = $unsigned(ang_c) + ROUND_HALF;
        cdeg  = ang_r[ZW:16];
        if (cdeg > MAX_CENTIDEG)
            cdeg = MAX_CENTIDEG;
        angle_next = dg_f ? '0 : cdeg[ANG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cd_vld[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
        degen_reg <= dg_f;
    end

    assign done           = done_reg;
    assign angle_centideg = angle_reg;
    assign degenerate     = degen_reg;

endmodule
`default_nettype wire

/* tb/sv/tb_three_point_vertex_angle_top.sv */
// self-checking testbench for the three point vertex angle block
`default_nettype none

// scoreboard: computes the expected angle for every accepted request and checks results
class vertex_angle_scoreboard;
    typedef struct packed {
        logic [14:0] angle;
        logic        degen;
    } angle_result_t;

    angle_result_t pending[$];
    int errors;

    static function logic [63:0] isqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    static function longint atan_step(int i);
        longint tbl [28] = '{294912000, 174096719, 91987925, 46694507, 23437865,
            11730358, 5866610, 2933484, 1466764, 733385, 366693, 183346, 91673,
            45837, 22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11,
            6, 3};
        return tbl[i];
    endfunction

    static function angle_result_t vertex_angle(logic signed [15:0] p[9]);
        longint u, v, dot, x, y, z, xs, ang;
        logic [63:0] su, sv, lu, lv, num, q, c, s, t;
        int eu, ev;
        angle_result_t r;
        su = 0; sv = 0; dot = 0;
        for (int i = 0; i < 3; i++) begin
            u = longint'(p[i]) - longint'(p[3+i]);
            v = longint'(p[6+i]) - longint'(p[3+i]);
            su += u * u;
            sv += v * v;
            dot += u * v;
        end
        if (su == 0 || sv == 0) begin
            r.angle = 0;
            r.degen = 1'b1;
            return r;
        end
        eu = 0; t = su;
        while (t < (64'd1 << 60)) begin t = t << 2; eu += 2; end
        lu = isqrt(t);
        ev = 0; t = sv;
        while (t < (64'd1 << 60)) begin t = t << 2; ev += 2; end
        lv = isqrt(t);
        num = (dot < 0 ? -dot : dot);
        num = num << ((eu + ev) / 2);
        q = (lu * lv) >> 30;
        c = num / q;
        if (c > (64'd1 << 30)) c = 64'd1 << 30;
        s = isqrt((64'd1 << 60) - c * c);
        x = c; y = s; z = 0;
        for (int i = 0; i < 28; i++) begin
            xs = x >>> i;
            if (y > 0) begin
                x += y >>> i;
                y -= xs;
                z += atan_step(i);
            end else if (y < 0) begin
                x += (-y) >> i;
                y += xs;
                z -= atan_step(i);
            end
        end
        ang = (dot < 0) ? 64'sd1179648000 - z : z;
        if (ang < 0) ang = 0;
        if (ang > 64'sd1179648000) ang = 64'sd1179648000;
        ang = (ang + 32768) >>> 16;
        if (ang > 18000) ang = 18000;
        r.angle = ang[14:0];
        r.degen = 1'b0;
        return r;
    endfunction

    function void note_request(logic signed [15:0] p[9]);
        pending.push_back(vertex_angle(p));
    endfunction

    function void check_result(logic [14:0] angle, logic degen);
        angle_result_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result angle=%0d degenerate=%0b", $time, angle, degen);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (angle !== e.angle) begin
            $display("%0t: angle mismatch expected %0d actual %0d", $time, e.angle, angle);
            errors++;
        end
        if (degen !== e.degen) begin
            $display("%0t: degenerate mismatch expected %0b actual %0b", $time, e.degen, degen);
            errors++;
        end
    endfunction
endclass

module tb_three_point_vertex_angle_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [15:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
    logic done;
    logic [14:0] angle_centideg;
    logic degenerate;

    vertex_angle_scoreboard sb;

    three_point_vertex_angle_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .a_x(a_x), .a_y(a_y), .a_z(a_z),
        .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .c_x(c_x), .c_y(c_y), .c_z(c_z),
        .done(done), .angle_centideg(angle_centideg), .degenerate(degenerate)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // results cannot be held off, so every done cycle is checked at its closing edge
    always @(posedge clk) begin
        if (rst_n && done) sb.check_result(angle_centideg, degenerate);
    end

    // present one request, hold start until it is taken, then drop start
    // unless another request follows with no gap
    task automatic send_request(input logic signed [15:0] p[9], input int gap);
        start <= 1'b1;
        {a_x, a_y, a_z} <= {p[0], p[1], p[2]};
        {b_x, b_y, b_z} <= {p[3], p[4], p[5]};
        {c_x, c_y, c_z} <= {p[6], p[7], p[8]};
        do @(posedge clk); while (busy);
        sb.note_request(p);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 40)) - 16'sd20;
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom_range(0, 4000)) - 16'sd2000;
        endcase
    endfunction

    // random idle gap, with some long runs of back to back requests
    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    initial begin
        logic signed [15:0] p[9];
        logic signed [15:0] directed[$][9];
        int wait_cycles;
        bit burst;
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: degenerate sides, coincident ends, right angle, straight
        // line, extremes of the coordinate range
        directed.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        directed.push_back('{5, 6, 7, 5, 6, 7, 1, 2, 3});
        directed.push_back('{1, 2, 3, 9, 9, 9, 9, 9, 9});
        directed.push_back('{10, 0, 0, 0, 0, 0, 10, 0, 0});
        directed.push_back('{10, 0, 0, 0, 0, 0, 0, 10, 0});
        directed.push_back('{10, 0, 0, 0, 0, 0, -10, 0, 0});
        directed.push_back('{1, 1, 0, 0, 0, 0, 1, 0, 0});
        directed.push_back('{32767, 32767, 32767, -32768, -32768, -32768,
                             32767, 32767, 32767});
        directed.push_back('{32767, 32767, 32767, -32768, -32768, -32768,
                             32767, -32768, 32767});
        directed.push_back('{-32768, 0, 0, 32767, 0, 0, 32767, 32767, 0});
        directed.push_back('{-32768, -32768, -32768, 32767, 32767, 32767,
                             -32768, -32768, -32767});
        directed.push_back('{1, 0, 0, 0, 0, 0, 0, 0, 1});
        directed.push_back('{3, 4, 0, 0, 0, 0, -3, 4, 0});
        directed.push_back('{32767, 0, 0, 0, 0, 0, 1, 1, 0});
        directed.push_back('{1, 0, 0, 0, 0, 0, -32768, 1, 0});
        directed.push_back('{-1, -1, -1, 0, 0, 0, 1, 1, 1});
        directed.push_back('{32767, 32767, 32767, 32767, 32767, 32767,
                             -32768, -32768, -32768});
        foreach (directed[k]) begin
            p = directed[k];
            send_request(p, $urandom_range(0, 3));
        end

        // random: mix of full range, small, extreme and mid coordinates,
        // with tiny offsets around the vertex to hit near-degenerate sides
        for (int n = 0; n < 850; n++) begin
            if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 9; i++) p[i] = rand_coord($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: for (int i = 0; i < 3; i++) p[i] = p[3+i];
                1: for (int i = 0; i < 3; i++) p[6+i] = p[i];
                2: for (int i = 0; i < 3; i++)
                       p[i] = p[3+i] + 16'($urandom_range(0, 2)) - 16'd1;
                default: ;
            endcase
            send_request(p, draw_gap(burst));
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 2000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (140) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
rtl/vang_pkg.sv
rtl/vang_sqrt_cell.sv
rtl/vang_div_cell.sv
rtl/vang_cordic_cell.sv
rtl/three_point_vertex_angle_top.sv
tb/sv/tb_three_point_vertex_angle_top.sv
